@@ design/msds_pkg.sv @@
// shared types, constants and helpers for the motif site distance scanner
package msds_pkg;

   // fixed field widths
   localparam int CHAR_BITS      = 8;
   localparam int FIELD_BITS     = 24;
   localparam int MOTIF_BITS     = 64;
   localparam int LENGTH_BITS    = 4;
   localparam int CSR_INDEX_BITS = 1;
   localparam int RSP_DATA_BITS  = 80;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - 3 * FIELD_BITS - 1;

   // register reset values: motif "ACGT", four characters in use
   localparam logic [MOTIF_BITS-1:0]  MOTIF_RESET  = 64'h0000_0000_5447_4341;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 4'd4;

   // ascii bounds for the case fold
   localparam logic [CHAR_BITS-1:0] LOWER_A    = 8'h61;
   localparam logic [CHAR_BITS-1:0] LOWER_Z    = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CASE_DELTA = 8'h20;

   typedef logic [CHAR_BITS-1:0]  char_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MOTIF_CHARS  = 1'b0,
      CSR_MOTIF_LENGTH = 1'b1
   } csr_index_type;

   // result kind codes
   typedef enum logic {
      KIND_DISTANCE = 1'b0,
      KIND_SUMMARY  = 1'b1
   } kind_type;

   // the results one input item causes: an optional distance and an optional summary
   typedef struct packed {
      logic      has_dist;
      logic      has_sum;
      field_type distance;
      field_type prefix;
      field_type postfix;
      logic      sites_valid;
   } result_pair_type;

   // fold a-z to upper case, leave every other byte alone
   function automatic char_type fold_upper(input char_type c);
      char_type r;
      r = c;
      if (c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

@@ design/motif_site_distance_scanner_unit.sv @@
// top level: motif window cell chain, match position tracking and result buffer
//
// Usage: one read character enters per item on req_ (tdata = character,
// tlast = final character of the read). The motif (csr index 0, first
// character in the low byte) and its length (csr index 1, 0 counts as 1,
// above MAX_MOTIF_CHARS counts as MAX_MOTIF_CHARS) are written on the csr_
// channel, which is always ready, between reads. Each match after the first
// gives a distance result item (tuser 0); the final character of a read gives
// a summary item (tuser 1, tlast 1) after any distance of that character.
// A result pair is registered in the output stage, or in the skid stage
// while that is busy. Throughput: one character per cycle while req_tready
// is high; a character that gives both a distance and a summary sends them
// as two items in turn, since the rsp_ channel carries one result per cycle.
// When the receiver stalls, one pair of results waits in the output register
// and one more in a skid stage; req_tready drops only while it is full.
// Reset: clears the window cells, the position and match tracking and both
// result stages, and loads motif "ACGT" with length 4.
module motif_site_distance_scanner_unit #(
   parameter int MAX_MOTIF_CHARS = 8,
   parameter int POSITION_BITS   = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items: tdata = character
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [msds_pkg::CHAR_BITS-1:0]         req_tdata,
   input  logic                                   req_tlast,
   // result items: tdata = distance, prefix, postfix, sites_valid, zero pad
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [msds_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tuser,   // kind
   output logic                                   rsp_tlast,
   // configuration writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [msds_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [msds_pkg::MOTIF_BITS-1:0]        csr_data
);

   localparam int LEN_BITS = $clog2(MAX_MOTIF_CHARS + 1);

   // configuration registers
   logic [msds_pkg::MOTIF_BITS-1:0]  motif_ff, motif_in;
   logic [msds_pkg::LENGTH_BITS-1:0] length_ff, length_in;

   // read tracking registers
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] last_match_ff, last_match_in;
   logic [POSITION_BITS-1:0] first_match_ff, first_match_in;
   logic                     any_match_ff, any_match_in;
   logic                     first_dist_ff, first_dist_in;

   logic                       accept;
   logic                       csr_write;
   msds_pkg::char_type         folded;
   logic [msds_pkg::LENGTH_BITS-1:0] len_clamp;
   logic [LEN_BITS-1:0]        len_eff;
   msds_pkg::char_type         cell_char [MAX_MOTIF_CHARS];
   logic [MAX_MOTIF_CHARS-1:0] eq_vec;
   logic [MAX_MOTIF_CHARS-1:0] use_vec;
   logic [POSITION_BITS:0]     pos_plus;
   logic [POSITION_BITS-1:0]   start;
   logic                       match;
   logic                       has_dist;
   logic                       push_ready;
   msds_pkg::result_pair_type  pair;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign folded    = msds_pkg::fold_upper(req_tdata);

   // configuration writes
   always_comb begin
      motif_in  = motif_ff;
      length_in = length_ff;
      if (csr_write) begin
         unique case (msds_pkg::csr_index_type'(csr_index))
            msds_pkg::CSR_MOTIF_CHARS:  motif_in  = csr_data;
            msds_pkg::CSR_MOTIF_LENGTH: length_in = csr_data[msds_pkg::LENGTH_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_ff  <= msds_pkg::MOTIF_RESET;
         length_ff <= msds_pkg::LENGTH_RESET;
      end else begin
         motif_ff  <= motif_in;
         length_ff <= length_in;
      end
   end

   // motif length in use
   always_comb begin
      if (length_ff == '0) begin
         len_clamp = msds_pkg::LENGTH_BITS'(1);
      end else if (length_ff > msds_pkg::LENGTH_BITS'(MAX_MOTIF_CHARS)) begin
         len_clamp = msds_pkg::LENGTH_BITS'(MAX_MOTIF_CHARS);
      end else begin
         len_clamp = length_ff;
      end
   end
   assign len_eff = LEN_BITS'(len_clamp);

   // window cell chain, cell k holds the character k places back
   for (genvar k = 0; k < MAX_MOTIF_CHARS; k++) begin : g_cell
      msds_pkg::char_type prev_char;
      msds_pkg::char_type match_char;
      logic [2:0]         idx;

      if (k == 0) begin : g_head
         assign prev_char = folded;
      end else begin : g_body
         assign prev_char = cell_char[k-1];
      end

      // newest character meets the last motif character
      assign idx        = 3'(len_clamp - msds_pkg::LENGTH_BITS'(k) - msds_pkg::LENGTH_BITS'(1));
      assign match_char = motif_ff[{idx, 3'b000} +: msds_pkg::CHAR_BITS];
      assign use_vec[k] = (msds_pkg::LENGTH_BITS'(k) < len_clamp);

      msds_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .clear      (req_tlast),
         .prev_char  (prev_char),
         .match_char (match_char),
         .char_ff    (cell_char[k]),
         .char_eq    (eq_vec[k])
      );
   end

   // match check and its start position
   assign pos_plus = {1'b0, pos_ff} + (POSITION_BITS + 1)'(1);
   assign start    = POSITION_BITS'(pos_plus - (POSITION_BITS + 1)'(len_eff));
   assign match    = (&(eq_vec | ~use_vec)) && (pos_plus >= (POSITION_BITS + 1)'(len_eff));
   assign has_dist = match && any_match_ff;

   // tracking update and result pair
   always_comb begin
      first_dist_in  = first_dist_ff || has_dist;
      first_match_in = (has_dist && !first_dist_ff) ? last_match_ff : first_match_ff;
      last_match_in  = match ? start : last_match_ff;
      any_match_in   = any_match_ff || match;

      pair.has_dist    = has_dist;
      pair.has_sum     = req_tlast;
      pair.distance    = msds_pkg::field_type'(start - last_match_ff);
      pair.sites_valid = first_dist_in;
      pair.prefix      = first_dist_in ? msds_pkg::field_type'(first_match_in) : '0;
      pair.postfix     = first_dist_in ? msds_pkg::field_type'(pos_ff - last_match_in) : '0;

      pos_in = pos_ff;
      if (req_tlast) begin
         pos_in         = '0;
         first_dist_in  = 1'b0;
         first_match_in = '0;
         last_match_in  = '0;
         any_match_in   = 1'b0;
      end else if (pos_ff != '1) begin
         pos_in = pos_plus[POSITION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         last_match_ff  <= '0;
         first_match_ff <= '0;
         any_match_ff   <= 1'b0;
         first_dist_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         last_match_ff  <= last_match_in;
         first_match_ff <= first_match_in;
         any_match_ff   <= any_match_in;
         first_dist_ff  <= first_dist_in;
      end
   end

   assign req_tready = push_ready;

   // result buffer
   msds_out_queue u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && (has_dist || req_tlast)),
      .push_pair  (pair),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/msds_cell.sv @@
// one window cell: holds a character, passes it on and compares the incoming one
module msds_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  clear,
   input  msds_pkg::char_type    prev_char,
   input  msds_pkg::char_type    match_char,
   output msds_pkg::char_type    char_ff,
   output logic                  char_eq
);

   msds_pkg::char_type char_in;

   // compare the character moving into this cell with its motif character
   assign char_eq = (prev_char == match_char);

   // next held character
   always_comb begin
      char_in = char_ff;
      if (shift_en) begin
         char_in = clear ? '0 : prev_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

endmodule

@@ design/msds_out_queue.sv @@
// result buffer: an output pair register plus a skid pair, one result item per cycle out while rsp_tready is high
module msds_out_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  msds_pkg::result_pair_type  push_pair,
   output logic                       push_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [msds_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   logic                      out_valid_ff, out_valid_in;
   msds_pkg::result_pair_type out_pair_ff, out_pair_in;
   logic                      phase_ff, phase_in;
   logic                      skid_valid_ff, skid_valid_in;
   msds_pkg::result_pair_type skid_pair_ff, skid_pair_in;

   logic pop;
   logic more;
   logic out_free;
   logic show_dist;

   // take a new pair only when the skid stage is empty
   assign push_ready = !skid_valid_ff;

   // the distance goes out first when the pair has one
   assign show_dist = out_pair_ff.has_dist && !phase_ff;
   assign pop       = out_valid_ff && rsp_tready;
   assign more      = out_pair_ff.has_dist && out_pair_ff.has_sum && !phase_ff;
   assign out_free  = !out_valid_ff || (pop && !more);

   // result item fields
   always_comb begin
      rsp_tvalid = out_valid_ff;
      if (show_dist) begin
         rsp_tuser = msds_pkg::KIND_DISTANCE;
         rsp_tlast = 1'b0;
         rsp_tdata = {msds_pkg::RSP_PAD_BITS'(0), 1'b0, msds_pkg::field_type'(0),
                      msds_pkg::field_type'(0), out_pair_ff.distance};
      end else begin
         rsp_tuser = msds_pkg::KIND_SUMMARY;
         rsp_tlast = 1'b1;
         rsp_tdata = {msds_pkg::RSP_PAD_BITS'(0), out_pair_ff.sites_valid,
                      out_pair_ff.postfix, out_pair_ff.prefix, msds_pkg::field_type'(0)};
      end
   end

   // pair movement between input, skid and output stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_pair_in   = out_pair_ff;
      phase_in      = phase_ff;
      skid_valid_in = skid_valid_ff;
      skid_pair_in  = skid_pair_ff;
      if (out_free) begin
         phase_in = 1'b0;
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_pair_in   = skid_pair_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_pair_in  = push_pair;
         end else begin
            out_valid_in = 1'b0;
         end
      end else begin
         if (pop) begin
            phase_in = 1'b1;
         end
         if (push) begin
            skid_valid_in = 1'b1;
            skid_pair_in  = push_pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         phase_ff      <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_pair_ff  <= out_pair_in;
      skid_pair_ff <= skid_pair_in;
   end

endmodule
